@@ src/mi3_pkg.sv @@
`timescale 1ns / 1ps
package mi3_pkg;

  // element format and fixed result widths
  localparam int ELEM_W    = 16;
  localparam int FRAC_BITS = 12;
  localparam int DET_OUT_W = 48;
  localparam int LANES     = 9;

  // derived datapath widths
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ADJ_W     = PROD_W + 1;
  localparam int DTERM_W   = ADJ_W + ELEM_W;
  localparam int DET_W     = DTERM_W + 2;
  localparam int NUM_SHIFT = 2 * FRAC_BITS + 1;
  localparam int DEN_W     = DET_W + 1;
  localparam int QB        = ELEM_W + 1;
  localparam int REM_W     = DEN_W + QB;

  typedef logic signed [ELEM_W-1:0]    elem_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [ADJ_W-1:0]     adj_t;
  typedef logic signed [DTERM_W-1:0]   dterm_t;
  typedef logic signed [DET_W-1:0]     det_t;
  typedef adj_t [LANES-1:0]            adj_vec_t;
  typedef elem_t [2:0]                 col_vec_t;

  // input word: one matrix
  typedef struct packed {
    elem_t m_r0c0;
    elem_t m_r0c1;
    elem_t m_r0c2;
    elem_t m_r1c0;
    elem_t m_r1c1;
    elem_t m_r1c2;
    elem_t m_r2c0;
    elem_t m_r2c1;
    elem_t m_r2c2;
  } mat_in_t;

  // result word
  typedef struct packed {
    elem_t                       inv_r0c0;
    elem_t                       inv_r0c1;
    elem_t                       inv_r0c2;
    elem_t                       inv_r1c0;
    elem_t                       inv_r1c1;
    elem_t                       inv_r1c2;
    elem_t                       inv_r2c0;
    elem_t                       inv_r2c1;
    elem_t                       inv_r2c2;
    logic signed [DET_OUT_W-1:0] det_value;
    logic                        singular;
    logic                        saturated;
  } inv_out_t;

  // adjugate plus third column, lane = row*3 + col
  typedef struct packed {
    adj_vec_t adj;
    col_vec_t col2;
  } adj_word_t;

  // adjugate plus exact determinant
  typedef struct packed {
    adj_vec_t adj;
    det_t     det;
  } det_word_t;

  // cyclic successor modulo 3
  function automatic int nxt3(input int x);
    return (x == 2) ? 0 : x + 1;
  endfunction

endpackage

@@ src/mi3_adj.sv @@
`timescale 1ns / 1ps
module mi3_adj (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_stall,
  input  mi3_pkg::mat_in_t    up_data,
  output logic                dn_valid,
  input  logic                dn_stall,
  output mi3_pkg::adj_word_t  dn_data
);
  import mi3_pkg::*;

  elem_t     col [3][3];  // col[c][r]
  logic      adv;
  logic      v1_r, v2_r;
  prod_t     p_nxt [LANES];
  prod_t     q_nxt [LANES];
  prod_t     p_r   [LANES];
  prod_t     q_r   [LANES];
  col_vec_t  col2_r;
  adj_word_t out_nxt;
  adj_word_t out_r;

  assign col[0][0] = up_data.m_r0c0;
  assign col[0][1] = up_data.m_r1c0;
  assign col[0][2] = up_data.m_r2c0;
  assign col[1][0] = up_data.m_r0c1;
  assign col[1][1] = up_data.m_r1c1;
  assign col[1][2] = up_data.m_r2c1;
  assign col[2][0] = up_data.m_r0c2;
  assign col[2][1] = up_data.m_r1c2;
  assign col[2][2] = up_data.m_r2c2;

  // whole block moves together unless the last word is held
  assign adv      = !(v2_r && dn_stall);
  assign up_stall = !adv;

  // stage 1: cross product partial products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        p_nxt[i*3+k] = col[nxt3(i)][nxt3(k)] * col[nxt3(nxt3(i))][nxt3(nxt3(k))];
        q_nxt[i*3+k] = col[nxt3(i)][nxt3(nxt3(k))] * col[nxt3(nxt3(i))][nxt3(k)];
      end
    end
  end

  // stage 2: adjugate differences
  always_comb begin
    out_nxt.col2 = col2_r;
    for (int l = 0; l < LANES; l++) begin
      out_nxt.adj[l] = adj_t'(p_r[l]) - adj_t'(q_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= up_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r       <= p_nxt;
      q_r       <= q_nxt;
      col2_r[0] <= col[2][0];
      col2_r[1] <= col[2][1];
      col2_r[2] <= col[2][2];
      out_r     <= out_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_data  = out_r;

endmodule

@@ src/mi3_det.sv @@
`timescale 1ns / 1ps
module mi3_det (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_stall,
  input  mi3_pkg::adj_word_t  up_data,
  output logic                dn_valid,
  input  logic                dn_stall,
  output mi3_pkg::det_word_t  dn_data
);
  import mi3_pkg::*;

  logic      adv;
  logic      v1_r, v2_r;
  dterm_t    term_nxt [3];
  dterm_t    term_r   [3];
  adj_vec_t  adj1_r;
  det_word_t out_r;

  assign adv      = !(v2_r && dn_stall);
  assign up_stall = !adv;

  // stage 1: third adjugate row times third column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term_nxt[k] = $signed(up_data.adj[6+k]) * $signed(up_data.col2[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= up_valid;
      v2_r <= v1_r;
    end
  end

  // stage 2: sum of the three terms
  always_ff @(posedge clk) begin
    if (adv) begin
      term_r    <= term_nxt;
      adj1_r    <= up_data.adj;
      out_r.adj <= adj1_r;
      out_r.det <= det_t'(term_r[0]) + det_t'(term_r[1]) + det_t'(term_r[2]);
    end
  end

  assign dn_valid = v2_r;
  assign dn_data  = out_r;

endmodule

@@ src/mi3_div.sv @@
`timescale 1ns / 1ps
module mi3_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_stall,
  input  mi3_pkg::det_word_t  up_data,
  output logic                dn_valid,
  input  logic                dn_stall,
  output mi3_pkg::inv_out_t   dn_data
);
  import mi3_pkg::*;

  localparam int NS = QB + 1;  // setup stage plus one stage per quotient bit
  localparam logic [QB-1:0] QPOS_LIM = {2'b00, {(ELEM_W-1){1'b1}}};
  localparam logic [QB-1:0] QNEG_LIM = {2'b01, {(ELEM_W-1){1'b0}}};
  localparam logic [ELEM_W-1:0] EMAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] EMIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic [DET_OUT_W-1:0] DMAX = {1'b0, {(DET_OUT_W-1){1'b1}}};
  localparam logic [DET_OUT_W-1:0] DMIN = {1'b1, {(DET_OUT_W-1){1'b0}}};

  logic                 adv;
  logic [NS-1:0]        v_r;
  logic [REM_W-1:0]     rem_r [NS][LANES];
  logic [QB-1:0]        quo_r [NS][LANES];
  logic                 neg_r [NS][LANES];
  logic                 ovf_r [NS][LANES];
  logic [DEN_W-1:0]     den_r [NS];
  logic                 zero_r [NS];
  logic [DET_OUT_W-1:0] detv_r [NS];

  // setup stage signals
  logic                 dneg;
  logic [DET_W-1:0]     dmag;
  logic [DEN_W-1:0]     den_nxt;
  logic [DET_W-1:0]     det_neg;
  logic [DET_W-DET_OUT_W:0] det_hi;
  logic [DET_OUT_W-1:0] detv_nxt;
  logic                 zero_nxt;
  logic [REM_W-1:0]     dlim;
  logic                 aneg [LANES];
  logic [ADJ_W-1:0]     aval [LANES];
  logic [ADJ_W-1:0]     amag [LANES];
  logic [REM_W-1:0]     num_nxt [LANES];
  logic                 ovf_nxt [LANES];
  logic                 neg_nxt [LANES];

  // division step signals
  logic [REM_W-1:0]     dsh [NS];
  logic [REM_W-1:0]     rem_nxt [NS][LANES];
  logic [QB-1:0]        quo_nxt [NS][LANES];

  // output stage signals
  logic [QB-1:0]        qv [LANES];
  logic [QB-1:0]        qn [LANES];
  logic                 clip [LANES];
  logic [ELEM_W-1:0]    ev [LANES];
  logic                 sat_any;
  logic                 vo_r;
  inv_out_t             out_nxt;
  inv_out_t             out_r;

  assign adv      = !(vo_r && dn_stall);
  assign up_stall = !adv;

  // setup: magnitudes, rounded numerators, early overflow, det clamp
  always_comb begin
    dneg     = up_data.det[DET_W-1];
    det_neg  = -up_data.det;
    dmag     = dneg ? det_neg : up_data.det;
    den_nxt  = {dmag, 1'b0};
    zero_nxt = (up_data.det == '0);
    dlim     = REM_W'(den_nxt) << QB;
    det_hi   = up_data.det[DET_W-1:DET_OUT_W-1];
    if ((&det_hi) || !(|det_hi)) begin
      detv_nxt = up_data.det[DET_OUT_W-1:0];
    end else begin
      detv_nxt = dneg ? DMIN : DMAX;
    end
    for (int l = 0; l < LANES; l++) begin
      aneg[l]    = up_data.adj[l][ADJ_W-1];
      aval[l]    = -up_data.adj[l];
      amag[l]    = aneg[l] ? aval[l] : up_data.adj[l];
      num_nxt[l] = (REM_W'(amag[l]) << NUM_SHIFT) + REM_W'(dmag);
      ovf_nxt[l] = (num_nxt[l] >= dlim);
      neg_nxt[l] = aneg[l] ^ dneg;
    end
  end

  // restoring steps, one quotient bit per stage, MSB first
  always_comb begin
    dsh[0] = '0;
    for (int l = 0; l < LANES; l++) begin
      rem_nxt[0][l] = '0;
      quo_nxt[0][l] = '0;
    end
    for (int s = 1; s < NS; s++) begin
      dsh[s] = REM_W'(den_r[s-1]) << (QB - s);
      for (int l = 0; l < LANES; l++) begin
        quo_nxt[s][l] = quo_r[s-1][l];
        if (rem_r[s-1][l] >= dsh[s]) begin
          rem_nxt[s][l]          = rem_r[s-1][l] - dsh[s];
          quo_nxt[s][l][QB - s]  = 1'b1;
        end else begin
          rem_nxt[s][l] = rem_r[s-1][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v_r  <= {v_r[NS-2:0], up_valid};
      vo_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0]  <= den_nxt;
      zero_r[0] <= zero_nxt;
      detv_r[0] <= detv_nxt;
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= num_nxt[l];
        quo_r[0][l] <= '0;
        neg_r[0][l] <= neg_nxt[l];
        ovf_r[0][l] <= ovf_nxt[l];
      end
      for (int s = 1; s < NS; s++) begin
        den_r[s]  <= den_r[s-1];
        zero_r[s] <= zero_r[s-1];
        detv_r[s] <= detv_r[s-1];
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= rem_nxt[s][l];
          quo_r[s][l] <= quo_nxt[s][l];
          neg_r[s][l] <= neg_r[s-1][l];
          ovf_r[s][l] <= ovf_r[s-1][l];
        end
      end
      out_r <= out_nxt;
    end
  end

  // sign, saturation and singular override
  always_comb begin
    sat_any = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      qv[l] = quo_r[NS-1][l];
      qn[l] = -qv[l];
      clip[l] = ovf_r[NS-1][l] ||
                (neg_r[NS-1][l] ? (qv[l] > QNEG_LIM) : (qv[l] > QPOS_LIM));
      if (zero_r[NS-1]) begin
        ev[l] = '0;
      end else if (clip[l]) begin
        ev[l]   = neg_r[NS-1][l] ? EMIN : EMAX;
        sat_any = 1'b1;
      end else begin
        ev[l] = neg_r[NS-1][l] ? qn[l][ELEM_W-1:0] : qv[l][ELEM_W-1:0];
      end
    end
    out_nxt.inv_r0c0  = ev[0];
    out_nxt.inv_r0c1  = ev[1];
    out_nxt.inv_r0c2  = ev[2];
    out_nxt.inv_r1c0  = ev[3];
    out_nxt.inv_r1c1  = ev[4];
    out_nxt.inv_r1c2  = ev[5];
    out_nxt.inv_r2c0  = ev[6];
    out_nxt.inv_r2c1  = ev[7];
    out_nxt.inv_r2c2  = ev[8];
    out_nxt.det_value = zero_r[NS-1] ? '0 : detv_r[NS-1];
    out_nxt.singular  = zero_r[NS-1];
    out_nxt.saturated = sat_any;
  end

  assign dn_valid = vo_r;
  assign dn_data  = out_r;

  // singular word carries no saturation and a zero determinant
  a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && out_r.singular |-> !out_r.saturated && out_r.det_value == '0)
    else $error("singular word with nonzero fields");

  // nonsingular word never reports a zero determinant
  a_det_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && !out_r.singular |-> out_r.det_value != '0)
    else $error("zero det_value on nonsingular word");

  // a held pipeline keeps its last divider word
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] && !adv |=> v_r[NS-1] && $stable(quo_r[NS-1][0]))
    else $error("divider word lost during stall");

endmodule

@@ src/matrix3_inverse_determinant_top.sv @@
`timescale 1ns / 1ps
// Pipeline: adjugate and determinant stages, 1 setup, 17 quotient-bit stages,
// 1 output. Throughput: one matrix per cycle while out_stall is low;
// nine restoring dividers run side by side, one quotient bit per stage.
// Reset (rst_n low, synchronous) clears only the valid bits; the datapath
// holds no state between words.
module matrix3_inverse_determinant_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mi3_pkg::mat_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mi3_pkg::inv_out_t  out_data
);
  import mi3_pkg::*;

  logic      adj_valid, adj_stall;
  adj_word_t adj_data;
  logic      det_valid, det_stall;
  det_word_t det_data;

  // cross products of column pairs
  mi3_adj u_adj (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .dn_valid (adj_valid),
    .dn_stall (adj_stall),
    .dn_data  (adj_data)
  );

  // determinant as dot product with the third column
  mi3_det u_det (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (adj_valid),
    .up_stall (adj_stall),
    .up_data  (adj_data),
    .dn_valid (det_valid),
    .dn_stall (det_stall),
    .dn_data  (det_data)
  );

  // per-element rounded division and saturation
  mi3_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (det_valid),
    .up_stall (det_stall),
    .up_data  (det_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (out_data)
  );

endmodule

@@ tb/sv/matrix3_inverse_determinant_top_tb.sv @@
`timescale 1ns / 1ps
module matrix3_inverse_determinant_top_tb;
  import mi3_pkg::*;

  localparam int LATENCY   = 23;
  localparam int MAX_CYCLE = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  mat_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  inv_out_t out_data;

  mat_in_t  matrix_q[$];
  inv_out_t inverse_q[$];
  int       errors = 0;
  int       cycle = 0;
  bit       quiet = 1'b0;    // no idling in the last part of the run
  bit       hold_off = 1'b0; // sender pauses until pipeline drains
  int       in_gap = 0;
  int       out_gap = 0;

  matrix3_inverse_determinant_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // round-to-nearest quotient of adjugate over det, saturated to 16 bits
  function automatic logic signed [15:0] inv_elem(input logic signed [127:0] adj,
                                                   input logic signed [127:0] det,
                                                   inout bit clip);
    logic [127:0] amag, dmag, q;
    logic signed [127:0] sq;
    amag = adj[127] ? -adj : adj;
    dmag = det[127] ? -det : det;
    q  = ((amag << 25) + dmag) / (dmag << 1);
    sq = (adj[127] != det[127]) ? -$signed(q) : $signed(q);
    if (sq > 32767) begin
      clip = 1'b1;
      return 16'sh7fff;
    end
    if (sq < -32768) begin
      clip = 1'b1;
      return 16'sh8000;
    end
    return sq[15:0];
  endfunction

  // expected inverse word for one matrix
  function automatic inv_out_t invert_matrix(input mat_in_t m);
    logic signed [127:0] a[3][3];
    logic signed [127:0] adj[3][3];
    logic signed [127:0] col[3][3];
    logic signed [127:0] det;
    logic signed [15:0]  e[9];
    inv_out_t r;
    bit clip;
    a[0][0] = m.m_r0c0; a[0][1] = m.m_r0c1; a[0][2] = m.m_r0c2;
    a[1][0] = m.m_r1c0; a[1][1] = m.m_r1c1; a[1][2] = m.m_r1c2;
    a[2][0] = m.m_r2c0; a[2][1] = m.m_r2c1; a[2][2] = m.m_r2c2;
    for (int c = 0; c < 3; c++)
      for (int rr = 0; rr < 3; rr++) col[c][rr] = a[rr][c];
    // adjugate row i = col(i+1) x col(i+2)
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        adj[i][k] = col[(i+1)%3][(k+1)%3] * col[(i+2)%3][(k+2)%3]
                  - col[(i+1)%3][(k+2)%3] * col[(i+2)%3][(k+1)%3];
    det = 0;
    for (int k = 0; k < 3; k++) det += adj[2][k] * col[2][k];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    clip = 1'b0;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) e[i*3+k] = inv_elem(adj[i][k], det, clip);
    r.inv_r0c0 = e[0]; r.inv_r0c1 = e[1]; r.inv_r0c2 = e[2];
    r.inv_r1c0 = e[3]; r.inv_r1c1 = e[4]; r.inv_r1c2 = e[5];
    r.inv_r2c0 = e[6]; r.inv_r2c1 = e[7]; r.inv_r2c2 = e[8];
    if (det > 128'sh7fff_ffff_ffff) r.det_value = 48'h7fff_ffff_ffff;
    else if (det < -128'sh8000_0000_0000) r.det_value = 48'h8000_0000_0000;
    else r.det_value = det[47:0];
    r.saturated = clip;
    return r;
  endfunction

  // driver: one word per accepted handshake
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) inverse_q.push_back(invert_matrix(in_data));
      if (in_valid && in_stall) begin
        // payload held
      end else if (hold_off || matrix_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (!quiet && $urandom_range(9) == 0) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(2);
      end else begin
        in_valid <= 1'b1;
        in_data  <= matrix_q.pop_front();
      end
      // receiver stall bursts
      if (quiet) out_stall <= 1'b0;
      else if (out_gap > 0) out_gap <= out_gap - 1;
      else if ($urandom_range(7) == 0) begin
        out_stall <= 1'b1;
        out_gap   <= $urandom_range(2);
      end else out_stall <= 1'b0;
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors <= errors + 1;
      end else begin
        inv_out_t want;
        want = inverse_q.pop_front();
        if (want !== out_data) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
          if (want.det_value !== out_data.det_value)
            $display("  det_value expected %h actual %h", want.det_value,
                     out_data.det_value);
          if (want.singular !== out_data.singular ||
              want.saturated !== out_data.saturated)
            $display("  flags expected %b%b actual %b%b", want.singular,
                     want.saturated, out_data.singular, out_data.saturated);
          errors <= errors + 1;
        end
      end
    end
  end

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(16384)) - 8192);
      3: return 16'(int'($urandom_range(32)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mat_in_t mat(input int d0, input int d1, input int d2,
                                  input int o);
    mat_in_t m;
    m = '{default: 16'(o)};
    m.m_r0c0 = 16'(d0); m.m_r1c1 = 16'(d1); m.m_r2c2 = 16'(d2);
    return m;
  endfunction

  task automatic wait_drained();
    while (matrix_q.size() != 0 || in_valid || inverse_q.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    mat_in_t m;
    // directed words
    matrix_q.push_back(mat(4096, 4096, 4096, 0));    // identity
    matrix_q.push_back('0);                          // all zero, singular
    m = '{default: 16'h7fff};
    matrix_q.push_back(m);                           // rank one, singular
    m = '{default: 16'h8000};
    matrix_q.push_back(m);
    matrix_q.push_back(mat(1, 1, 1, 0));             // tiny det, inverse clips
    matrix_q.push_back(mat(-1, 1, 1, 0));            // clips negative
    matrix_q.push_back(mat(16'h8000, 16'h8000, 16'h8000, 0));
    matrix_q.push_back(mat(16'h7fff, 16'h7fff, 16'h7fff, 0));
    matrix_q.push_back(mat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    matrix_q.push_back(mat(8192, -8192, 2048, 0));
    matrix_q.push_back(mat(4096, 4096, 4096, 1)); // tie rounding cases
    matrix_q.push_back(mat(3, 5, 7, 0));
    matrix_q.push_back(mat(-4096, -4096, -4096, 0));
    m = mat(16'h8000, 16'h8000, 16'h8000, 0);
    m.m_r0c1 = 16'h7fff; m.m_r1c2 = 16'h7fff; m.m_r2c0 = 16'h7fff;
    matrix_q.push_back(m); // extreme entries whose det terms nearly cancel
    m = mat(4096, 4096, 0, 0);
    m.m_r2c0 = 4096; m.m_r2c1 = 4096; // dependent rows
    matrix_q.push_back(m);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();
    // random words: well scaled, extreme and deliberately singular
    for (int n = 0; n < 600; n++) begin
      m = '{m_r0c0: rand_elem(), m_r0c1: rand_elem(), m_r0c2: rand_elem(),
            m_r1c0: rand_elem(), m_r1c1: rand_elem(), m_r1c2: rand_elem(),
            m_r2c0: rand_elem(), m_r2c1: rand_elem(), m_r2c2: rand_elem()};
      if ($urandom_range(15) == 0) begin
        m.m_r2c0 = m.m_r0c0; m.m_r2c1 = m.m_r0c1; m.m_r2c2 = m.m_r0c2;
      end
      matrix_q.push_back(m);
      if (n == 300) begin
        while (matrix_q.size() != 0) @(posedge clk);
        hold_off <= 1'b1;
        while (in_valid || inverse_q.size() != 0) @(posedge clk);
        hold_off <= 1'b0;
      end
      if (n == 500) quiet <= 1'b1;
    end
    wait_drained();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // run limit
  always @(posedge clk) begin
    if (cycle > MAX_CYCLE) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

@@ matrix3_inverse_determinant_top.f @@
src/mi3_pkg.sv
src/mi3_adj.sv
src/mi3_det.sv
src/mi3_div.sv
src/matrix3_inverse_determinant_top.sv
tb/sv/matrix3_inverse_determinant_top_tb.sv
